// File: hw/rtl/chsp_pkg.sv
package chsp_pkg;

    // Action codes of a request.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_VAL   = 2'd1;
    localparam logic [1:0] ACT_VD    = 2'd2;
    localparam logic [1:0] ACT_VDR   = 2'd3;

    // Status codes of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SPACING = 2'd0;
    localparam t_cfg_idx CFG_SEGCNT  = 2'd1;

    // Divider widths: position over spacing with 30 fraction bits, node
    // difference term over spacing, derivative over position.
    localparam int Q1W = 62;
    localparam int N2W = 57;
    localparam int N3W = 63;

    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         node_index;
        logic signed [31:0] node_value;
        logic signed [31:0] node_slope;
        logic [31:0]        position;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] derivative;
        logic [1:0]         status;
    } t_rsp;

    typedef struct packed {
        logic [1:0]         action;
        logic [9:0]         node_index;
        logic signed [31:0] node_value;
        logic signed [31:0] node_slope;
        logic [31:0]        position;
        logic [31:0]        spacing;
        logic [9:0]         seg_count;
    } t_side1;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        position;
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [35:0] e;
        logic               neg;
    } t_side2;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] dfix;
        logic [1:0]         status;
        logic               use_q;
        logic               neg;
    } t_side3;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/chsp_div.sv
module chsp_div #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    // Restoring division, one quotient bit per stage. The numerator word
    // shifts left and takes the quotient bits in at its low end.

    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_num  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic          r_vld  [NW];

    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] n_num  [NW];
    logic [DW-1:0] n_den  [NW];
    logic [SW-1:0] n_side [NW];
    logic          n_vld  [NW];

    always_comb begin
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_den;
        logic [DW:0]   w_part;
        logic [DW:0]   w_diff;
        logic          w_ge;
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                p_rem     = '0;
                p_num     = i_num;
                p_den     = i_den;
                n_side[k] = i_side;
                n_vld[k]  = i_valid;
            end else begin
                p_rem     = r_rem[k-1];
                p_num     = r_num[k-1];
                p_den     = r_den[k-1];
                n_side[k] = r_side[k-1];
                n_vld[k]  = r_vld[k-1];
            end
            w_part   = {p_rem, p_num[NW-1]};
            w_ge     = (w_part >= {1'b0, p_den});
            w_diff   = w_part - {1'b0, p_den};
            n_rem[k] = w_ge ? w_diff[DW-1:0] : w_part[DW-1:0];
            n_num[k] = {p_num[NW-2:0], w_ge};
            n_den[k] = p_den;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NW; k++) begin
            r_rem[k]  <= n_rem[k];
            r_num[k]  <= n_num[k];
            r_den[k]  <= n_den[k];
            r_side[k] <= n_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NW; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// File: hw/rtl/chsp_tab.sv
module chsp_tab #(
    parameter  int MAX_NODES = 1024,
    localparam int AW        = $clog2(MAX_NODES)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wvalue,
    input  logic signed [31:0] i_wslope,
    input  logic [AW-1:0]      i_raddr0,
    input  logic [AW-1:0]      i_raddr1,
    output logic signed [31:0] o_y0,
    output logic signed [31:0] o_y1,
    output logic signed [31:0] o_m0,
    output logic signed [31:0] o_m1
);
    // Node value and slope tables, one write and two registered reads each.

    logic [31:0] r_val_mem [MAX_NODES];
    logic [31:0] r_slp_mem [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_val_mem[i_waddr] <= i_wvalue;
            r_slp_mem[i_waddr] <= i_wslope;
        end
    end

    always_ff @(posedge i_clk) begin
        o_y0 <= r_val_mem[i_raddr0];
        o_y1 <= r_val_mem[i_raddr1];
        o_m0 <= r_slp_mem[i_raddr0];
        o_m1 <= r_slp_mem[i_raddr1];
    end

endmodule

// File: hw/rtl/chsp_mac.sv
module chsp_mac #(
    parameter int MAX_NODES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [chsp_pkg::Q1W-1:0]  i_quo,
    input  chsp_pkg::t_side1          i_side,
    output logic                      o_valid,
    output logic [chsp_pkg::N2W-1:0]  o_num,
    output logic [31:0]               o_den,
    output chsp_pkg::t_side2          o_side
);
    import chsp_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] position;
        logic [31:0] spacing;
        logic [1:0]  status;
    } t_ctl;

    // Stage A: segment check, table access, t squared.
    logic [31:0]        w_seg;
    logic [29:0]        w_t;
    logic               w_oor;
    logic               w_we;
    t_ctl               w_ctl;
    logic signed [31:0] w_y0, w_y1, w_m0, w_m1;

    assign w_seg = i_quo[61:30];
    assign w_t   = i_quo[29:0];
    assign w_oor = (i_side.spacing == '0) || (w_seg >= {22'b0, i_side.seg_count})
                   || (({1'b0, w_seg} + 33'd1) >= 33'(MAX_NODES));
    assign w_we  = i_valid && (i_side.action == ACT_WRITE)
                   && ({22'b0, i_side.node_index} < 32'(MAX_NODES));

    always_comb begin
        w_ctl.action   = i_side.action;
        w_ctl.position = i_side.position;
        w_ctl.spacing  = i_side.spacing;
        w_ctl.status   = ((i_side.action != ACT_WRITE) && w_oor) ? ST_RANGE : ST_OK;
    end

    chsp_tab #(.MAX_NODES(MAX_NODES)) u_tab (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (AW'(i_side.node_index)),
        .i_wvalue (i_side.node_value),
        .i_wslope (i_side.node_slope),
        .i_raddr0 (AW'(w_seg)),
        .i_raddr1 (AW'(w_seg + 32'd1)),
        .o_y0     (w_y0),
        .o_y1     (w_y1),
        .o_m0     (w_m0),
        .o_m1     (w_m1)
    );

    logic        r_a_vld;
    t_ctl        r_a_ctl;
    logic [29:0] r_a_t;
    logic [59:0] r_a_tt;

    // Stage B and C: t cubed, node difference.
    logic               r_b_vld;
    t_ctl               r_b_ctl;
    logic [29:0]        r_b_t, r_b_t2;
    logic signed [31:0] r_b_y0, r_b_y1, r_b_m0, r_b_m1;
    logic signed [32:0] r_b_dy;

    logic               r_c_vld;
    t_ctl               r_c_ctl;
    logic [29:0]        r_c_t, r_c_t2;
    logic [59:0]        r_c_t23;
    logic signed [31:0] r_c_y0, r_c_y1, r_c_m0, r_c_m1;
    logic signed [32:0] r_c_dy;

    // Stage D: Hermite basis and its derivative.
    logic signed [34:0] w_st, w_st2, w_st3;
    logic signed [34:0] w_b00, w_b01, w_b10, w_b11, w_d01, w_d10, w_d11;

    assign w_st  = $signed({5'b0, r_c_t});
    assign w_st2 = $signed({5'b0, r_c_t2});
    assign w_st3 = $signed({5'b0, r_c_t23[59:30]});
    assign w_b00 = ONE_Q30 - 35'sd3 * w_st2 + 35'sd2 * w_st3;
    assign w_b01 = 35'sd3 * w_st2 - 35'sd2 * w_st3;
    assign w_b10 = w_st - 35'sd2 * w_st2 + w_st3;
    assign w_b11 = w_st3 - w_st2;
    assign w_d01 = 35'sd6 * w_st - 35'sd6 * w_st2;
    assign w_d10 = ONE_Q30 - 35'sd4 * w_st + 35'sd3 * w_st2;
    assign w_d11 = 35'sd3 * w_st2 - 35'sd2 * w_st;

    logic               r_d_vld;
    t_ctl               r_d_ctl;
    logic signed [32:0] r_d_b00, r_d_b01, r_d_b10, r_d_b11, r_d_d01, r_d_d10, r_d_d11;
    logic signed [31:0] r_d_y0, r_d_y1, r_d_m0, r_d_m1;
    logic signed [32:0] r_d_dy;

    // Stage E: node times basis products.
    logic               r_e_vld;
    t_ctl               r_e_ctl;
    logic signed [64:0] r_e_p00, r_e_p01, r_e_p10, r_e_p11, r_e_pd10, r_e_pd11;
    logic signed [65:0] r_e_pd01;

    // Stage F: slope terms scaled by the grid step.
    logic signed [33:0] w_h;
    assign w_h = $signed({2'b0, r_e_ctl.spacing});

    logic               r_f_vld;
    t_ctl               r_f_ctl;
    logic signed [35:0] r_f_v0, r_f_a, r_f_e;
    logic signed [68:0] r_f_q10, r_f_q11;

    // Stage G: value sum and saturation, numerator for the step division.
    logic signed [63:0] w_val;
    logic signed [35:0] w_amag;
    t_side2             w_side2;

    assign w_val  = 64'(r_f_v0) + 64'(r_f_q10 >>> 24) + 64'(r_f_q11 >>> 24);
    assign w_amag = r_f_a[35] ? -r_f_a : r_f_a;

    always_comb begin
        w_side2.action   = r_f_ctl.action;
        w_side2.position = r_f_ctl.position;
        w_side2.status   = r_f_ctl.status;
        w_side2.e        = r_f_e;
        w_side2.neg      = r_f_a[35];
        if ((r_f_ctl.action == ACT_WRITE) || (r_f_ctl.status == ST_RANGE)) begin
            w_side2.value = '0;
        end else begin
            w_side2.value = f_sat32(w_val);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctl  <= w_ctl;
        r_a_t    <= w_t;
        r_a_tt   <= w_t * w_t;

        r_b_ctl  <= r_a_ctl;
        r_b_t    <= r_a_t;
        r_b_t2   <= r_a_tt[59:30];
        r_b_y0   <= w_y0;
        r_b_y1   <= w_y1;
        r_b_m0   <= w_m0;
        r_b_m1   <= w_m1;
        r_b_dy   <= 33'(w_y1) - 33'(w_y0);

        r_c_ctl  <= r_b_ctl;
        r_c_t    <= r_b_t;
        r_c_t2   <= r_b_t2;
        r_c_t23  <= r_b_t2 * r_b_t;
        r_c_y0   <= r_b_y0;
        r_c_y1   <= r_b_y1;
        r_c_m0   <= r_b_m0;
        r_c_m1   <= r_b_m1;
        r_c_dy   <= r_b_dy;

        r_d_ctl  <= r_c_ctl;
        r_d_b00  <= 33'(w_b00);
        r_d_b01  <= 33'(w_b01);
        r_d_b10  <= 33'(w_b10);
        r_d_b11  <= 33'(w_b11);
        r_d_d01  <= 33'(w_d01);
        r_d_d10  <= 33'(w_d10);
        r_d_d11  <= 33'(w_d11);
        r_d_y0   <= r_c_y0;
        r_d_y1   <= r_c_y1;
        r_d_m0   <= r_c_m0;
        r_d_m1   <= r_c_m1;
        r_d_dy   <= r_c_dy;

        r_e_ctl  <= r_d_ctl;
        r_e_p00  <= r_d_y0 * r_d_b00;
        r_e_p01  <= r_d_y1 * r_d_b01;
        r_e_p10  <= r_d_m0 * r_d_b10;
        r_e_p11  <= r_d_m1 * r_d_b11;
        r_e_pd01 <= r_d_dy * r_d_d01;
        r_e_pd10 <= r_d_m0 * r_d_d10;
        r_e_pd11 <= r_d_m1 * r_d_d11;

        r_f_ctl  <= r_e_ctl;
        r_f_v0   <= 36'(r_e_p00 >>> 30) + 36'(r_e_p01 >>> 30);
        r_f_q10  <= 35'(r_e_p10 >>> 30) * w_h;
        r_f_q11  <= 35'(r_e_p11 >>> 30) * w_h;
        r_f_a    <= 36'(r_e_pd01 >>> 30);
        r_f_e    <= 36'(r_e_pd10 >>> 30) + 36'(r_e_pd11 >>> 30);

        o_num    <= {w_amag[32:0], 24'b0};
        o_den    <= r_f_ctl.spacing;
        o_side   <= w_side2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            o_valid <= r_f_vld;
        end
    end

endmodule

// File: hw/rtl/cubic_hermite_spline_eval.sv
// Uniform cubic Hermite spline evaluator, signed Q16.16 results.
// Requests enter on start when busy is low; busy is always low, so one
// request can be taken on every clock. A write request stores one node's
// value and slope; value, derivative and derivative-over-r requests look up
// the segment of the position and combine its two bounding nodes.
// Every request returns exactly one result: o_rsp_valid is high for one
// cycle with value, derivative and status. The receiver cannot stall.
// The spacing and segment count registers are written through the cfg
// channel, which is always ready; they are sampled as a request enters.
// Throughput is one request per cycle. The depth is set by three
// bit-per-stage dividers (62, 57 and 63 stages) plus ten stages of table
// access, multiply and add. Tables are written in request order at the
// stage where they are read, so ordering always holds.
// Reset clears all valid bits and loads spacing 1.0 and one segment. The
// node tables are not cleared; read only nodes that were written.
module cubic_hermite_spline_eval #(
    parameter int MAX_NODES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  chsp_pkg::t_req      i_req,
    output logic                o_rsp_valid,
    output chsp_pkg::t_rsp      o_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  chsp_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import chsp_pkg::*;

    localparam logic signed [59:0] DER_LIM = 60'sd549755813888;

    // Configuration registers.
    logic [31:0] r_spacing;
    logic [9:0]  r_seg_count;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= 32'h0100_0000;
            r_seg_count <= 10'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SPACING: r_spacing   <= i_cfg_data;
                CFG_SEGCNT:  r_seg_count <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // The first divider gives the segment in its upper quotient bits and the
    // local parameter t, in Q0.30, in its lower 30 bits.
    t_side1             w_side1;
    logic               w_d1_vld;
    logic [Q1W-1:0]     w_d1_quo;
    t_side1             w_d1_side;

    always_comb begin
        w_side1.action     = i_req.action;
        w_side1.node_index = i_req.node_index;
        w_side1.node_value = i_req.node_value;
        w_side1.node_slope = i_req.node_slope;
        w_side1.position   = i_req.position;
        w_side1.spacing    = r_spacing;
        w_side1.seg_count  = r_seg_count;
    end

    chsp_div #(.NW(Q1W), .DW(32), .SW($bits(t_side1))) u_div_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_num   ({i_req.position, 30'b0}),
        .i_den   (r_spacing),
        .i_side  (w_side1),
        .o_valid (w_d1_vld),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side)
    );

    // Table access and the polynomial datapath.
    logic               w_m_vld;
    logic [N2W-1:0]     w_m_num;
    logic [31:0]        w_m_den;
    t_side2             w_m_side;

    chsp_mac #(.MAX_NODES(MAX_NODES)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d1_vld),
        .i_quo   (w_d1_quo),
        .i_side  (w_d1_side),
        .o_valid (w_m_vld),
        .o_num   (w_m_num),
        .o_den   (w_m_den),
        .o_side  (w_m_side)
    );

    // The node difference term is divided by the grid step; the quotient
    // is truncated toward zero, so the sign is applied afterwards.
    logic               w_d2_vld;
    logic [N2W-1:0]     w_d2_quo;
    t_side2             w_d2_side;

    chsp_div #(.NW(N2W), .DW(32), .SW($bits(t_side2))) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m_vld),
        .i_num   (w_m_num),
        .i_den   (w_m_den),
        .i_side  (w_m_side),
        .o_valid (w_d2_vld),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side)
    );

    // Derivative assembly.
    logic signed [59:0] w_q2s;
    logic               r_h_vld;
    logic signed [59:0] r_h_der;
    t_side2             r_h_side;

    assign w_q2s = $signed({3'b0, w_d2_quo});

    always_ff @(posedge i_clk) begin
        r_h_der  <= (w_d2_side.neg ? -w_q2s : w_q2s) + 60'(w_d2_side.e);
        r_h_side <= w_d2_side;
    end

    // Per-mode derivative selection. Only the divided mode with a
    // derivative below the clamp limit needs the last division.
    logic signed [59:0] w_dmag;
    t_side3             w_side3;
    logic               r_i_vld;
    logic [N3W-1:0]     r_i_num;
    logic [31:0]        r_i_den;
    t_side3             r_i_side;

    assign w_dmag = r_h_der[59] ? -r_h_der : r_h_der;

    always_comb begin
        w_side3.value  = r_h_side.value;
        w_side3.dfix   = '0;
        w_side3.status = r_h_side.status;
        w_side3.use_q  = 1'b0;
        w_side3.neg    = r_h_der[59];
        if (r_h_side.status == ST_OK) begin
            unique case (r_h_side.action)
                ACT_WRITE: ;
                ACT_VAL:   ;
                ACT_VD:    w_side3.dfix = f_sat32(64'(r_h_der));
                ACT_VDR: begin
                    priority if (r_h_side.position == '0) begin
                        w_side3.status = ST_ZERO;
                    end else if (r_h_der >= DER_LIM) begin
                        w_side3.dfix = 32'sh7fffffff;
                    end else if (r_h_der <= -DER_LIM) begin
                        w_side3.dfix = 32'sh80000000;
                    end else begin
                        w_side3.use_q = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_num  <= {w_dmag[38:0], 24'b0};
        r_i_den  <= r_h_side.position;
        r_i_side <= w_side3;
    end

    logic               w_d3_vld;
    logic [N3W-1:0]     w_d3_quo;
    t_side3             w_d3_side;

    chsp_div #(.NW(N3W), .DW(32), .SW($bits(t_side3))) u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_i_vld),
        .i_num   (r_i_num),
        .i_den   (r_i_den),
        .i_side  (r_i_side),
        .o_valid (w_d3_vld),
        .o_quo   (w_d3_quo),
        .o_side  (w_d3_side)
    );

    // Output register.
    logic signed [63:0] w_q3s;
    logic signed [63:0] w_q3v;
    t_rsp               n_rsp;

    assign w_q3s = $signed({1'b0, w_d3_quo});
    assign w_q3v = w_d3_side.neg ? -w_q3s : w_q3s;

    always_comb begin
        n_rsp.value      = w_d3_side.value;
        n_rsp.derivative = w_d3_side.use_q ? f_sat32(w_q3v) : w_d3_side.dfix;
        n_rsp.status     = w_d3_side.status;
    end

    always_ff @(posedge i_clk) begin
        o_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld     <= 1'b0;
            r_i_vld     <= 1'b0;
            o_rsp_valid <= 1'b0;
        end else begin
            r_h_vld     <= w_d2_vld;
            r_i_vld     <= r_h_vld;
            o_rsp_valid <= w_d3_vld;
        end
    end

    // An out-of-range segment returns no value and no derivative.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_RANGE)
        |-> (o_rsp.value == '0) && (o_rsp.derivative == '0))
        else $error("range status with nonzero result");

    // A zero position in divided mode returns a zero derivative.
    a_zero_der: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_ZERO) |-> (o_rsp.derivative == '0))
        else $error("zero position status with nonzero derivative");

    // The position divider is only used with a valid, nonzero divisor.
    a_div_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i_vld && r_i_side.use_q |-> (r_i_side.status == ST_OK) && (r_i_den != '0))
        else $error("position division with bad status or zero divisor");

endmodule

// File: tb/cubic_hermite_spline_eval_tb.sv
`timescale 1ns / 100ps

module cubic_hermite_spline_eval_tb;
    import chsp_pkg::*;

    // The block answers every request through its pipeline; the watchdog
    // limit covers that pipeline with a wide margin.
    localparam int TAB_DEPTH   = 1024;
    localparam int DRAIN_WAIT  = 250;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 70;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_rsp_valid;
    t_rsp       o_rsp;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    logic [31:0] i_cfg_data;

    cubic_hermite_spline_eval DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's state: registers and node tables.
    logic [31:0]        cur_spacing;
    logic [9:0]         cur_segcnt;
    logic signed [31:0] value_tab [TAB_DEPTH];
    logic signed [31:0] slope_tab [TAB_DEPTH];
    bit                 node_written [TAB_DEPTH];

    t_rsp pending_rsp [$];
    int   error_count;
    int   stall_cycles;
    bit   quiet_stretch;

    // One row of the directed part. When check_typed is set, the result is
    // compared with the value typed into the row instead of the prediction.
    typedef struct {
        t_req req;
        bit   check_typed;
        t_rsp typed_rsp;
    } t_row;

    t_row directed_rows [$];

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Works out the result of one request and applies its table write.
    // Products return to Q16.16 by arithmetic shifts (floor); the divisions
    // truncate toward zero, as SystemVerilog division of signed values does.
    function automatic t_rsp predict_spline(input t_req r);
        t_rsp            res;
        longint unsigned pos, sp, seg, x;
        longint          h, t, t2, t3, y0, y1, m0, m1, val, der, a, q, lim, one;
        longint          b00, b01, b10, b11, d01, d10, d11;
        res = '0;
        one = longint'(1) << 30;
        if (r.action == ACT_WRITE) begin
            value_tab[r.node_index] = r.node_value;
            slope_tab[r.node_index] = r.node_slope;
            node_written[r.node_index] = 1'b1;
            return res;
        end
        if (cur_spacing == 0) begin
            res.status = ST_RANGE;
            return res;
        end
        pos = 64'(r.position);
        sp  = 64'(cur_spacing);
        seg = pos / sp;
        if (seg >= cur_segcnt || seg + 1 >= TAB_DEPTH) begin
            res.status = ST_RANGE;
            return res;
        end
        h  = longint'(sp);
        x  = pos - seg * sp;
        t  = longint'((x << 30) / sp);
        t2 = longint'((longint'(t) * longint'(t)) >> 30);
        t3 = longint'((t2 * t) >> 30);
        y0 = value_tab[seg];
        y1 = value_tab[seg + 1];
        m0 = slope_tab[seg];
        m1 = slope_tab[seg + 1];

        b00 = one - 3 * t2 + 2 * t3;
        b01 = 3 * t2 - 2 * t3;
        b10 = t - 2 * t2 + t3;
        b11 = t3 - t2;
        val = ((y0 * b00) >>> 30) + ((y1 * b01) >>> 30)
            + ((((m0 * b10) >>> 30) * h) >>> 24)
            + ((((m1 * b11) >>> 30) * h) >>> 24);
        res.value = clamp_q16(val);
        if (r.action == ACT_VAL) begin
            return res;
        end

        d01 = 6 * t - 6 * t2;
        d10 = one - 4 * t + 3 * t2;
        d11 = 3 * t2 - 2 * t;
        a   = ((y1 - y0) * d01) >>> 30;
        der = (a * (longint'(1) << 24)) / h + ((m0 * d10) >>> 30) + ((m1 * d11) >>> 30);
        if (r.action == ACT_VD) begin
            res.derivative = clamp_q16(der);
            return res;
        end

        // Divided mode: a zero position flags the result but keeps the value.
        if (pos == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        lim = longint'(1) << 39;
        if (der >= lim) begin
            q = 64'sd2147483647;
        end else if (der <= -lim) begin
            q = -64'sd2147483648;
        end else begin
            q = (der * (longint'(1) << 24)) / longint'(pos);
        end
        res.derivative = clamp_q16(q);
        return res;
    endfunction

    // Outside a quiet stretch, each cycle before a request idles with a chance of 37 in a hundred.
    function automatic int pick_gap();
        int gap;
        gap = 0;
        if (!quiet_stretch) begin
            while ($urandom_range(99) < 37) begin
                gap++;
            end
        end
        return gap;
    endfunction

    // Presents one request, holds it until the block takes it, and files the
    // expected result. A gap lowers start first, in a step of its own.
    task automatic send_request(input t_req r, input bit use_typed, input t_rsp typed);
        int   gap;
        t_rsp predicted;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = predict_spline(r);
        pending_rsp.push_back(use_typed ? typed : predicted);
    endtask

    // Registers change only while nothing is in flight.
    task automatic write_register(input t_cfg_idx idx, input logic [31:0] data);
        start <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SPACING) begin
            cur_spacing = data;
        end else begin
            cur_segcnt = data[9:0];
        end
    endtask

    task automatic send_write(input logic [9:0] idx);
        t_req r;
        r.action     = ACT_WRITE;
        r.node_index = idx;
        r.position   = $urandom();
        // Mostly moderate node data, sometimes the full range to hit saturation.
        if ($urandom_range(3) == 0) begin
            r.node_value = $urandom();
            r.node_slope = $urandom();
        end else begin
            r.node_value = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            r.node_slope = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        end
        send_request(r, 1'b0, '0);
    endtask

    // Random evaluation. Positions mostly fall inside the segments in use;
    // any node the segment needs that was never written is written first.
    task automatic send_evaluation();
        t_req            r;
        longint unsigned seg, pos;
        r            = '0;
        r.action     = 2'($urandom_range(1, 3));
        r.node_index = 10'($urandom());
        r.node_value = $urandom();
        r.node_slope = $urandom();
        pos = 64'($urandom());
        if ($urandom_range(99) < 85 && cur_spacing != 0) begin
            seg = 64'($urandom_range(32'(cur_segcnt) - 1));
            pos = seg * 64'(cur_spacing) + 64'($urandom_range(cur_spacing - 1));
            if ($urandom_range(19) == 0) begin
                pos = seg * 64'(cur_spacing);
            end
            if (pos > 64'hffffffff) begin
                pos = 64'($urandom());
            end
        end
        r.position = pos[31:0];
        if (cur_spacing != 0) begin
            seg = 64'(r.position) / 64'(cur_spacing);
            if (seg < cur_segcnt && seg + 1 < TAB_DEPTH) begin
                if (!node_written[seg]) send_write(seg[9:0]);
                if (!node_written[seg + 1]) send_write(seg[9:0] + 10'd1);
            end
        end
        send_request(r, 1'b0, '0);
    endtask

    function automatic void add_row(input logic [1:0] act, input logic [9:0] idx,
                                    input logic [31:0] val, input logic [31:0] slp,
                                    input logic [31:0] pos, input bit typed,
                                    input logic [31:0] exp_val, input logic [1:0] exp_st);
        t_row row;
        row.req.action     = act;
        row.req.node_index = idx;
        row.req.node_value = val;
        row.req.node_slope = slp;
        row.req.position   = pos;
        row.check_typed    = typed;
        row.typed_rsp      = '{value: exp_val, derivative: 32'd0, status: exp_st};
        directed_rows.push_back(row);
    endfunction

    // Results are taken at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result value=%h derivative=%h status=%0d",
                         $time, o_rsp.value, o_rsp.derivative, o_rsp.status);
                error_count++;
            end else begin
                t_rsp want;
                want = pending_rsp.pop_front();
                if (o_rsp.value !== want.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, o_rsp.value);
                    error_count++;
                end
                if (o_rsp.derivative !== want.derivative) begin
                    $display("%0t: derivative expected %h actual %h",
                             $time, want.derivative, o_rsp.derivative);
                    error_count++;
                end
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_rsp.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted request, result or register write resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_rsp_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] spacing_set [7];
        logic [9:0]  segcnt_set [7];
        quiet_stretch = 1'b0;
        cur_spacing   = 32'h01000000;
        cur_segcnt    = 10'd1;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req         = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SPACING;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset settings: spacing 1.0, one segment.
        // Write requests always answer with all fields zero.
        add_row(ACT_WRITE, 10'd0, 32'h00010000, 32'h00008000, 32'hffffffff, 1'b1, 32'h0, ST_OK);
        add_row(ACT_WRITE, 10'd1, 32'h7fffffff, 32'h80000000, 32'h0, 1'b1, 32'h0, ST_OK);
        // At position zero the value is node 0 itself; divided mode flags it.
        add_row(ACT_VDR, 10'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h00010000, ST_ZERO);
        add_row(ACT_VAL, 10'd0, 32'h0, 32'h0, 32'h00800000, 1'b0, 32'h0, ST_OK);
        add_row(ACT_VD, 10'd0, 32'h0, 32'h0, 32'h00ffffff, 1'b0, 32'h0, ST_OK);
        add_row(ACT_VDR, 10'd0, 32'h0, 32'h0, 32'h00400000, 1'b0, 32'h0, ST_OK);
        // A tiny position makes the divided derivative saturate.
        add_row(ACT_VDR, 10'd0, 32'h0, 32'h0, 32'h00000001, 1'b0, 32'h0, ST_OK);
        // Segment one and beyond are out of range with one segment in use.
        add_row(ACT_VAL, 10'd0, 32'h0, 32'h0, 32'h01000000, 1'b1, 32'h0, ST_RANGE);
        add_row(ACT_VD, 10'd0, 32'h0, 32'h0, 32'hffffffff, 1'b1, 32'h0, ST_RANGE);
        add_row(ACT_WRITE, 10'd1023, 32'h80000000, 32'h7fffffff, 32'h0, 1'b1, 32'h0, ST_OK);
        add_row(ACT_WRITE, 10'd1, 32'h80000000, 32'h7fffffff, 32'h0, 1'b1, 32'h0, ST_OK);
        add_row(ACT_VAL, 10'd0, 32'h0, 32'h0, 32'h00c00000, 1'b0, 32'h0, ST_OK);
        add_row(ACT_VD, 10'd0, 32'h0, 32'h0, 32'h00000000, 1'b0, 32'h0, ST_OK);
        add_row(ACT_VDR, 10'd0, 32'h0, 32'h0, 32'h00000100, 1'b0, 32'h0, ST_OK);
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].check_typed,
                         directed_rows[i].typed_rsp);
        end

        // With zero spacing every evaluation is out of range.
        write_register(CFG_SPACING, 32'h0);
        add_row(ACT_VAL, 10'd0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, ST_RANGE);
        add_row(ACT_VDR, 10'd0, 32'h0, 32'h0, 32'h12345678, 1'b1, 32'h0, ST_RANGE);
        for (int i = directed_rows.size() - 2; i < directed_rows.size(); i++) begin
            send_request(directed_rows[i].req, 1'b1, directed_rows[i].typed_rsp);
        end

        // Random phases over several settings, the extremes among them.
        spacing_set = '{32'h00100000, 32'h00000001, 32'hffffffff, 32'h0,
                        32'h00400000, 32'h00010000, 32'h01000000};
        segcnt_set  = '{10'd16, 10'd1023, 10'd1, 10'd5, 10'd40, 10'd1023, 10'd3};
        for (int p = 0; p < 7; p++) begin
            if (p == 4) begin
                spacing_set[p] = $urandom_range(32'h00010000, 32'h02000000);
                segcnt_set[p]  = 10'($urandom_range(2, 60));
            end
            write_register(CFG_SPACING, spacing_set[p]);
            write_register(CFG_SEGCNT, {22'b0, segcnt_set[p]});
            quiet_stretch = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(9) == 0) begin
                    send_write(10'($urandom()));
                end else begin
                    send_evaluation();
                end
            end
        end
        start <= 1'b0;

        wait (pending_rsp.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
